// ----- hdl/ctrv_pkg.sv -----
// ---------------------------------------------------------------------------
// ctrv_pkg
// Shared widths, fixed-point constants and the arctangent table of the CTRV
// position predictor.
// ---------------------------------------------------------------------------
package ctrv_pkg;

  localparam int FracBits = 16;
  localparam int unsigned TrigIterDefault = 18;

  // field widths
  localparam int SpeedW = 24;
  localparam int YawW   = 21;
  localparam int HorizW = 24;
  localparam int PosW   = 48;
  localparam int HeadW  = 19;
  localparam int QuatW  = 18;
  localparam int ThrW   = 20;

  localparam int InDataW  = 256;
  localparam int OutDataW = 96;

  localparam logic [ThrW-1:0] ThrReset = 20'd7;

  // trig pipeline
  localparam int ThetaW    = 30;  // Q16 angle into the trig unit
  localparam int AngW      = 44;  // offset angle, Q30, always positive
  localparam int RedStages = 11;  // quotient of the 2*pi reduction fits 11 bits
  localparam int CordW     = 34;
  localparam int TrigW     = 20;
  localparam int TrigFixedLat = RedStages + 4;  // input, two fold stages, rounding

  localparam logic [AngW-1:0] TwoPiQ30U = 44'd6746518852;
  localparam logic [AngW-1:0] AngOffset = 44'd6908435304448;  // 1024 * 2*pi
  localparam logic signed [CordW-1:0] TwoPiQ30  = 34'sd6746518852;
  localparam logic signed [CordW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [CordW-1:0] RndQ14    = 34'sd8192;

  // divider
  localparam int NumW   = 44;
  localparam int QuotW  = NumW + 1;
  localparam int DivLat = NumW + 2;

  // back end
  localparam int LyW   = 32;
  localparam int LocW  = 46;
  localparam int RotW  = 38;
  localparam int ProdW = 84;
  localparam int AccW  = 86;

  function automatic logic signed [CordW-1:0] atan_q30(input int unsigned idx);
    logic signed [CordW-1:0] r;
    unique case (idx)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      24: r = 34'sd64;
      25: r = 34'sd32;
      26: r = 34'sd16;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/ctrv_trig.sv -----
// ---------------------------------------------------------------------------
// ctrv_trig
// Pipelined sine/cosine: reduction modulo 2*pi by restoring subtraction,
// fold into [-pi/2, pi/2], rotation-mode CORDIC, rounding back to Q16.
// ---------------------------------------------------------------------------
module ctrv_trig #(
  parameter int unsigned TrigIterations = ctrv_pkg::TrigIterDefault
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ctrv_pkg::ThetaW-1:0]  angle_i,
  output logic signed [ctrv_pkg::TrigW-1:0]   sin_o,
  output logic signed [ctrv_pkg::TrigW-1:0]   cos_o
);
  import ctrv_pkg::*;

  logic [AngW-1:0] red_d [RedStages+1];
  logic [AngW-1:0] red_q [RedStages+1];

  logic signed [CordW-1:0] f1_d, f1_q;

  logic signed [CordW-1:0] x_d [TrigIterations+1];
  logic signed [CordW-1:0] x_q [TrigIterations+1];
  logic signed [CordW-1:0] y_d [TrigIterations+1];
  logic signed [CordW-1:0] y_q [TrigIterations+1];
  logic signed [CordW-1:0] z_d [TrigIterations+1];
  logic signed [CordW-1:0] z_q [TrigIterations+1];
  logic                    fl_d [TrigIterations+1];
  logic                    fl_q [TrigIterations+1];

  logic signed [AngW+1:0]  ext;
  logic signed [CordW-1:0] rs, xf, yf, cr, sr;
  logic signed [TrigW-1:0] sin_d, cos_d;

  always_comb begin
    ext = (46'(angle_i) <<< (30 - FracBits)) + $signed({2'b00, AngOffset});
    red_d[0] = ext[AngW-1:0];
    for (int k = 0; k < RedStages; k++) begin
      if (red_q[k] >= (TwoPiQ30U << (RedStages - 1 - k))) begin
        red_d[k+1] = red_q[k] - (TwoPiQ30U << (RedStages - 1 - k));
      end else begin
        red_d[k+1] = red_q[k];
      end
    end

    // remainder is below 2*pi, so 33 bits
    rs = $signed({1'b0, red_q[RedStages][CordW-2:0]});
    f1_d = (rs > PiQ30) ? rs - TwoPiQ30 : rs;

    x_d[0] = GainQ30;
    y_d[0] = '0;
    priority if (f1_q > HalfPiQ30) begin
      z_d[0]  = f1_q - PiQ30;
      fl_d[0] = 1'b1;
    end else if (f1_q < -HalfPiQ30) begin
      z_d[0]  = f1_q + PiQ30;
      fl_d[0] = 1'b1;
    end else begin
      z_d[0]  = f1_q;
      fl_d[0] = 1'b0;
    end

    for (int i = 0; i < TrigIterations; i++) begin
      fl_d[i+1] = fl_q[i];
      if (z_q[i] >= 0) begin
        x_d[i+1] = x_q[i] - (y_q[i] >>> i);
        y_d[i+1] = y_q[i] + (x_q[i] >>> i);
        z_d[i+1] = z_q[i] - atan_q30(i);
      end else begin
        x_d[i+1] = x_q[i] + (y_q[i] >>> i);
        y_d[i+1] = y_q[i] - (x_q[i] >>> i);
        z_d[i+1] = z_q[i] + atan_q30(i);
      end
    end

    xf = fl_q[TrigIterations] ? -x_q[TrigIterations] : x_q[TrigIterations];
    yf = fl_q[TrigIterations] ? -y_q[TrigIterations] : y_q[TrigIterations];
    cr = (xf + RndQ14) >>> (30 - FracBits);
    sr = (yf + RndQ14) >>> (30 - FracBits);
    cos_d = cr[TrigW-1:0];
    sin_d = sr[TrigW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q <= red_d;
      f1_q  <= f1_d;
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      fl_q  <= fl_d;
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// ----- hdl/ctrv_div.sv -----
// ---------------------------------------------------------------------------
// ctrv_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero.
// ---------------------------------------------------------------------------
module ctrv_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [ctrv_pkg::NumW-1:0]   num_i,
  input  logic signed [ctrv_pkg::YawW-1:0]   den_i,
  output logic signed [ctrv_pkg::QuotW-1:0]  quot_o
);
  import ctrv_pkg::*;

  logic [YawW-1:0] rem_d [NumW+1];
  logic [YawW-1:0] rem_q [NumW+1];
  logic [NumW-1:0] nq_d  [NumW+1];
  logic [NumW-1:0] nq_q  [NumW+1];
  logic [YawW-1:0] dv_d  [NumW+1];
  logic [YawW-1:0] dv_q  [NumW+1];
  logic            neg_d [NumW+1];
  logic            neg_q [NumW+1];
  logic [YawW:0]   part  [NumW];
  logic            ge    [NumW];

  logic signed [NumW-1:0]  num_neg;
  logic signed [YawW-1:0]  den_neg;
  logic [NumW-1:0]         qm;
  logic signed [QuotW-1:0] quot_d;

  always_comb begin
    // magnitude of the most negative value comes out right as unsigned
    num_neg  = -num_i;
    den_neg  = -den_i;
    rem_d[0] = '0;
    nq_d[0]  = num_i[NumW-1] ? num_neg : num_i;
    dv_d[0]  = den_i[YawW-1] ? den_neg : den_i;
    neg_d[0] = num_i[NumW-1] ^ den_i[YawW-1];
    for (int k = 0; k < NumW; k++) begin
      part[k] = {rem_q[k], nq_q[k][NumW-1]};
      ge[k]   = part[k] >= {1'b0, dv_q[k]};
      rem_d[k+1] = ge[k] ? YawW'(part[k] - {1'b0, dv_q[k]}) : part[k][YawW-1:0];
      nq_d[k+1]  = {nq_q[k][NumW-2:0], ge[k]};
      dv_d[k+1]  = dv_q[k];
      neg_d[k+1] = neg_q[k];
    end
    qm     = nq_q[NumW];
    quot_d = neg_q[NumW] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      dv_q   <= dv_d;
      neg_q  <= neg_d;
      quot_o <= quot_d;
    end
  end

endmodule

// ----- hdl/ctrv_future_position.sv -----
// ---------------------------------------------------------------------------
// ctrv_future_position
// CTRV position predictor: straight or arc displacement, rotated into the
// world frame by heading or quaternion, added to the position, saturated.
// ---------------------------------------------------------------------------
//  channel   dir  width  content
//  s_axis    in   256+1  one motion state word, tuser selects quaternion
//  m_axis    out  96     predicted x, y
//  cfg       in   20     turn threshold, Q4.16 rad/s
//
// One word per cycle while the skid register is empty. The path from accept to tvalid
// runs through the CORDIC chain and the 46-stage divider.
// Reset clears all valid bits and sets the threshold to 7.
// The whole pipeline holds while the skid register is full; a stall loses
// and repeats nothing.
module ctrv_future_position #(
  parameter int unsigned TrigIterations = ctrv_pkg::TrigIterDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // speed, yaw_rate, horizon, pos_x, pos_y, heading_angle, quat_w, quat_x,
  // quat_y, quat_z
  input  logic [ctrv_pkg::InDataW-1:0]      s_axis_tdata,
  // use_quaternion
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // future_x, future_y
  output logic [ctrv_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_wr_en_i,
  input  logic [ctrv_pkg::ThrW-1:0]         cfg_wr_data_i
);
  import ctrv_pkg::*;

  localparam int TrigLat = TrigFixedLat + int'(TrigIterations);

  typedef struct packed {
    logic signed [SpeedW-1:0] speed;
    logic signed [YawW-1:0]   yaw;
    logic [HorizW-1:0]        horizon;
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [HeadW-1:0]  heading;
    logic                     use_quat;
    logic signed [QuatW-1:0]  qw;
    logic signed [QuatW-1:0]  qx;
    logic signed [QuatW-1:0]  qy;
    logic signed [QuatW-1:0]  qz;
  } in_t;

  typedef struct packed {
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [SpeedW-1:0] speed;
    logic signed [YawW-1:0]   yaw;
    logic                     arc;
    logic                     use_quat;
    logic signed [LyW-1:0]    ly_st;
    logic signed [QuatW-1:0]  qw;
    logic signed [QuatW-1:0]  qx;
    logic signed [QuatW-1:0]  qy;
    logic signed [QuatW-1:0]  qz;
  } trig_side_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic                   arc;
    logic signed [LyW-1:0]  ly_st;
    logic signed [RotW-1:0] rxx;
    logic signed [RotW-1:0] rxy;
    logic signed [RotW-1:0] ryx;
    logic signed [RotW-1:0] ryy;
  } div_side_t;

  localparam logic signed [RotW-1:0] OneQ2F = 38'sd4294967296;
  localparam logic signed [AccW-1:0] RndQ2F = 86'sd2147483648;

  function automatic logic [PosW-1:0] sat_pos(input logic signed [PosW+6:0] v);
    logic [PosW-1:0] r;
    if (v[PosW+6:PosW-1] != {8{v[PosW+6]}}) begin
      r = v[PosW+6] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      r = v[PosW-1:0];
    end
    return r;
  endfunction

  logic en;
  logic [ThrW-1:0] thr_q;

  // front stages
  logic p1_vld_q, p2_vld_q, p3_vld_q;
  in_t  p1_d, p1_q, p2_q;
  logic signed [47:0] p2_vt_d, p2_vt_q;
  logic signed [45:0] p2_wt_d, p2_wt_q;
  logic [YawW-1:0]    abs_yaw;
  logic               p2_arc_d, p2_arc_q;
  logic signed [48:0] vt_r;
  logic signed [46:0] wt_r;
  trig_side_t         p3_side_d, p3_side_q;
  logic signed [ThetaW-1:0] p3_theta_d, p3_theta_q, p3_hd_d, p3_hd_q;

  // trig outputs and aligned side data
  logic signed [TrigW-1:0] sin_a, cos_a, sin_b, cos_b;
  logic       tdl_vld_q [TrigLat];
  trig_side_t tdl_q     [TrigLat];

  // product stage
  logic q4_vld_q;
  trig_side_t q4_side_q;
  logic signed [TrigW-1:0]   one_minus_c;
  logic signed [NumW-1:0]    q4_numx_d, q4_numx_q, q4_numy_d, q4_numy_q;
  logic signed [TrigW-1:0]   q4_sb_q, q4_cb_q;
  logic signed [2*QuatW-1:0] q4_qxx_q, q4_qyy_q, q4_qzz_q, q4_qxy_q, q4_qwz_q;
  div_side_t  ddl_d0;

  // divider outputs and aligned side data
  logic signed [QuotW-1:0] quot_x, quot_y;
  logic       ddl_vld_q [DivLat];
  div_side_t  ddl_q     [DivLat];

  // back end
  logic q6_vld_q, q7_vld_q, q8_vld_q, q9_vld_q;
  logic signed [LocW-1:0]  q6_lx_d, q6_lx_q, q6_ly_d, q6_ly_q;
  div_side_t               q6_side_q;
  logic signed [RotW-1:0]  rsel [4];
  logic signed [LocW-1:0]  lsel [4];
  logic signed [61:0]      pl_d [4];
  logic signed [61:0]      pl_q [4];
  logic signed [60:0]      ph_d [4];
  logic signed [60:0]      ph_q [4];
  logic signed [ProdW-1:0] pr_d [4];
  logic signed [ProdW-1:0] pr_q [4];
  logic signed [PosW-1:0]  q7_px_q, q7_py_q, q8_px_q, q8_py_q, q9_px_q, q9_py_q;
  logic signed [AccW-1:0]  q9_ax_d, q9_ax_q, q9_ay_d, q9_ay_q;
  logic signed [AccW-1:0]  shx, shy;
  logic signed [PosW+6:0]  sumx, sumy;
  logic [OutDataW-1:0]     res;

  // output register and skid
  logic                out_vld_q, skid_vld_q, push;
  logic [OutDataW-1:0] out_q, skid_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;
  assign push          = q9_vld_q && en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_wr_en_i) begin
      thr_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    p1_d.speed    = s_axis_tdata[23:0];
    p1_d.yaw      = s_axis_tdata[44:24];
    p1_d.horizon  = s_axis_tdata[68:45];
    p1_d.pos_x    = s_axis_tdata[116:69];
    p1_d.pos_y    = s_axis_tdata[164:117];
    p1_d.heading  = s_axis_tdata[183:165];
    p1_d.qw       = s_axis_tdata[201:184];
    p1_d.qx       = s_axis_tdata[219:202];
    p1_d.qy       = s_axis_tdata[237:220];
    p1_d.qz       = s_axis_tdata[255:238];
    p1_d.use_quat = s_axis_tuser;

    p2_vt_d  = 48'(p1_q.speed) * 48'($signed({1'b0, p1_q.horizon}));
    p2_wt_d  = 46'(p1_q.yaw) * 46'($signed({1'b0, p1_q.horizon}));
    abs_yaw  = p1_q.yaw[YawW-1] ? -p1_q.yaw : p1_q.yaw;
    p2_arc_d = (p1_q.yaw != '0) && (abs_yaw >= {1'b0, thr_q});

    vt_r = (49'(p2_vt_q) + 49'sd32768) >>> FracBits;
    wt_r = (47'(p2_wt_q) + 47'sd32768) >>> FracBits;
    p3_theta_d = wt_r[ThetaW-1:0];
    p3_hd_d    = ThetaW'(p2_q.heading);
    p3_side_d.pos_x    = p2_q.pos_x;
    p3_side_d.pos_y    = p2_q.pos_y;
    p3_side_d.speed    = p2_q.speed;
    p3_side_d.yaw      = p2_q.yaw;
    p3_side_d.arc      = p2_arc_q;
    p3_side_d.use_quat = p2_q.use_quat;
    p3_side_d.ly_st    = vt_r[LyW-1:0];
    p3_side_d.qw       = p2_q.qw;
    p3_side_d.qx       = p2_q.qx;
    p3_side_d.qy       = p2_q.qy;
    p3_side_d.qz       = p2_q.qz;
  end

  ctrv_trig #(.TrigIterations(TrigIterations)) u_trig_arc (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (p3_theta_q),
    .sin_o   (sin_a),
    .cos_o   (cos_a)
  );

  ctrv_trig #(.TrigIterations(TrigIterations)) u_trig_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (p3_hd_q),
    .sin_o   (sin_b),
    .cos_o   (cos_b)
  );

  always_comb begin
    one_minus_c = 20'sd65536 - cos_a;
    q4_numx_d   = NumW'(tdl_q[TrigLat-1].speed) * NumW'(one_minus_c);
    q4_numy_d   = NumW'(sin_a) * NumW'(tdl_q[TrigLat-1].speed);

    ddl_d0.pos_x = q4_side_q.pos_x;
    ddl_d0.pos_y = q4_side_q.pos_y;
    ddl_d0.arc   = q4_side_q.arc;
    ddl_d0.ly_st = q4_side_q.ly_st;
    if (q4_side_q.use_quat) begin
      ddl_d0.rxx = OneQ2F - ((RotW'(q4_qyy_q) + RotW'(q4_qzz_q)) <<< 1);
      ddl_d0.rxy = (RotW'(q4_qxy_q) - RotW'(q4_qwz_q)) <<< 1;
      ddl_d0.ryx = (RotW'(q4_qxy_q) + RotW'(q4_qwz_q)) <<< 1;
      ddl_d0.ryy = OneQ2F - ((RotW'(q4_qxx_q) + RotW'(q4_qzz_q)) <<< 1);
    end else begin
      ddl_d0.rxx = RotW'(q4_sb_q) <<< FracBits;
      ddl_d0.rxy = RotW'(q4_cb_q) <<< FracBits;
      ddl_d0.ryx = -(RotW'(q4_cb_q) <<< FracBits);
      ddl_d0.ryy = RotW'(q4_sb_q) <<< FracBits;
    end
  end

  ctrv_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (q4_numx_q),
    .den_i  (q4_side_q.yaw),
    .quot_o (quot_x)
  );

  ctrv_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (q4_numy_q),
    .den_i  (q4_side_q.yaw),
    .quot_o (quot_y)
  );

  always_comb begin
    if (ddl_q[DivLat-1].arc) begin
      q6_lx_d = -LocW'(quot_x);
      q6_ly_d = LocW'(quot_y);
    end else begin
      q6_lx_d = '0;
      q6_ly_d = LocW'(ddl_q[DivLat-1].ly_st);
    end

    rsel[0] = q6_side_q.rxx;  lsel[0] = q6_lx_q;
    rsel[1] = q6_side_q.rxy;  lsel[1] = q6_ly_q;
    rsel[2] = q6_side_q.ryx;  lsel[2] = q6_lx_q;
    rsel[3] = q6_side_q.ryy;  lsel[3] = q6_ly_q;
    // local split into a low unsigned half and a high signed half
    for (int k = 0; k < 4; k++) begin
      pl_d[k] = 62'(rsel[k]) * 62'($signed({1'b0, lsel[k][22:0]}));
      ph_d[k] = 61'(rsel[k]) * 61'($signed(lsel[k][LocW-1:23]));
      pr_d[k] = (ProdW'(ph_q[k]) <<< 23) + ProdW'(pl_q[k]);
    end

    q9_ax_d = AccW'(pr_q[0]) + AccW'(pr_q[1]) + RndQ2F;
    q9_ay_d = AccW'(pr_q[2]) + AccW'(pr_q[3]) + RndQ2F;

    shx  = q9_ax_q >>> (2 * FracBits);
    shy  = q9_ay_q >>> (2 * FracBits);
    sumx = shx[PosW+6:0] + (PosW+7)'(q9_px_q);
    sumy = shy[PosW+6:0] + (PosW+7)'(q9_py_q);
    res  = {sat_pos(sumy), sat_pos(sumx)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      q4_vld_q <= 1'b0;
      q6_vld_q <= 1'b0;
      q7_vld_q <= 1'b0;
      q8_vld_q <= 1'b0;
      q9_vld_q <= 1'b0;
      for (int i = 0; i < TrigLat; i++) tdl_vld_q[i] <= 1'b0;
      for (int i = 0; i < DivLat; i++) ddl_vld_q[i] <= 1'b0;
    end else if (en) begin
      p1_vld_q     <= s_axis_tvalid;
      p2_vld_q     <= p1_vld_q;
      p3_vld_q     <= p2_vld_q;
      tdl_vld_q[0] <= p3_vld_q;
      for (int i = 1; i < TrigLat; i++) tdl_vld_q[i] <= tdl_vld_q[i-1];
      q4_vld_q     <= tdl_vld_q[TrigLat-1];
      ddl_vld_q[0] <= q4_vld_q;
      for (int i = 1; i < DivLat; i++) ddl_vld_q[i] <= ddl_vld_q[i-1];
      q6_vld_q     <= ddl_vld_q[DivLat-1];
      q7_vld_q     <= q6_vld_q;
      q8_vld_q     <= q7_vld_q;
      q9_vld_q     <= q8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q       <= p1_d;
      p2_q       <= p1_q;
      p2_vt_q    <= p2_vt_d;
      p2_wt_q    <= p2_wt_d;
      p2_arc_q   <= p2_arc_d;
      p3_side_q  <= p3_side_d;
      p3_theta_q <= p3_theta_d;
      p3_hd_q    <= p3_hd_d;
      tdl_q[0]   <= p3_side_q;
      for (int i = 1; i < TrigLat; i++) tdl_q[i] <= tdl_q[i-1];
      q4_side_q  <= tdl_q[TrigLat-1];
      q4_numx_q  <= q4_numx_d;
      q4_numy_q  <= q4_numy_d;
      q4_sb_q    <= sin_b;
      q4_cb_q    <= cos_b;
      q4_qxx_q   <= tdl_q[TrigLat-1].qx * tdl_q[TrigLat-1].qx;
      q4_qyy_q   <= tdl_q[TrigLat-1].qy * tdl_q[TrigLat-1].qy;
      q4_qzz_q   <= tdl_q[TrigLat-1].qz * tdl_q[TrigLat-1].qz;
      q4_qxy_q   <= tdl_q[TrigLat-1].qx * tdl_q[TrigLat-1].qy;
      q4_qwz_q   <= tdl_q[TrigLat-1].qw * tdl_q[TrigLat-1].qz;
      ddl_q[0]   <= ddl_d0;
      for (int i = 1; i < DivLat; i++) ddl_q[i] <= ddl_q[i-1];
      q6_side_q  <= ddl_q[DivLat-1];
      q6_lx_q    <= q6_lx_d;
      q6_ly_q    <= q6_ly_d;
      pl_q       <= pl_d;
      ph_q       <= ph_d;
      q7_px_q    <= q6_side_q.pos_x;
      q7_py_q    <= q6_side_q.pos_y;
      pr_q       <= pr_d;
      q8_px_q    <= q7_px_q;
      q8_py_q    <= q7_py_q;
      q9_ax_q    <= q9_ax_d;
      q9_ay_q    <= q9_ay_d;
      q9_px_q    <= q8_px_q;
      q9_py_q    <= q8_py_q;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the CTRV position predictor: directed and random
// motion states through the stream ports, with random gaps and a long output
// hold-off, checked word by word against a bit-exact predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ctrv_pkg::*;

  localparam int          NumRandom = 800;
  localparam int          Limit     = 20000;
  localparam int          DrainWait = 200;
  localparam logic [ThrW-1:0] ThrMax = 20'hFFFFF;
  localparam longint      Q30TwoPi  = 64'sd6746518852;
  localparam longint      Q30Pi     = 64'sd3373259426;
  localparam longint      Q30HalfPi = 64'sd1686629713;
  localparam longint      Q30Gain   = 64'sd652032874;
  localparam longint      PosMax    = 64'sd140737488355327;

  typedef struct {
    logic signed [SpeedW-1:0] speed;
    logic signed [YawW-1:0]   yaw;
    logic [HorizW-1:0]        horizon;
    logic signed [PosW-1:0]   px;
    logic signed [PosW-1:0]   py;
    logic signed [HeadW-1:0]  heading;
    logic                     use_quat;
    logic signed [QuatW-1:0]  qw, qx, qy, qz;
  } motion_t;

  // arithmetic shift right with rounding, half up
  function automatic longint round_shift(longint x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic void sin_cos(input longint ang_q16, output longint s,
                                  output longint c);
    longint a, x, y, nx;
    bit     flip;
    a = ang_q16 * (64'sd1 <<< (30 - FracBits));
    x = Q30Gain;
    y = 0;
    flip = 0;
    a = a % Q30TwoPi;
    if (a < 0) a += Q30TwoPi;
    if (a > Q30Pi) a -= Q30TwoPi;
    if (a > Q30HalfPi) begin
      a -= Q30Pi;
      flip = 1;
    end else if (a < -Q30HalfPi) begin
      a += Q30Pi;
      flip = 1;
    end
    for (int i = 0; i < TrigIterDefault && i < 32; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= longint'(atan_q30(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += longint'(atan_q30(i));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = round_shift(x, 30 - FracBits);
    s = round_shift(y, 30 - FracBits);
  endfunction

  function automatic logic [PosW-1:0] world_coord(longint pos, longint ra, longint rb,
                                                  longint lx, longint ly);
    logic signed [127:0] acc;
    acc = 128'(ra) * 128'(lx) + 128'(rb) * 128'(ly);
    acc = (acc + (128'sd1 <<< (2 * FracBits - 1))) >>> (2 * FracBits);
    acc = acc + 128'(pos);
    if (acc > 128'(PosMax)) return PosMax[PosW-1:0];
    if (acc < -128'(PosMax) - 1) return {1'b1, {(PosW-1){1'b0}}};
    return acc[PosW-1:0];
  endfunction

  function automatic logic [OutDataW-1:0] predict_position(motion_t m,
                                                           logic [ThrW-1:0] thr);
    longint one, one2, v, w, t, absw, lx, ly, s, c, rxx, rxy, ryx, ryy;
    longint qw, qx, qy, qz;
    one = 64'sd1 <<< FracBits;
    one2 = 64'sd1 <<< (2 * FracBits);
    v = m.speed;
    w = m.yaw;
    t = longint'({1'b0, m.horizon});
    absw = (w < 0) ? -w : w;
    lx = 0;
    ly = round_shift(v * t, FracBits);
    if (w != 0 && absw >= longint'({1'b0, thr})) begin
      sin_cos(round_shift(w * t, FracBits), s, c);
      lx = -((v * (one - c)) / w);
      ly = (s * v) / w;
    end
    qw = m.qw;
    qx = m.qx;
    qy = m.qy;
    qz = m.qz;
    if (m.use_quat) begin
      rxx = one2 - 2 * (qy * qy + qz * qz);
      rxy = 2 * (qx * qy - qw * qz);
      ryx = 2 * (qx * qy + qw * qz);
      ryy = one2 - 2 * (qx * qx + qz * qz);
    end else begin
      sin_cos(m.heading, s, c);
      rxx = s * one;
      rxy = c * one;
      ryx = -c * one;
      ryy = s * one;
    end
    return {world_coord(m.py, ryx, ryy, lx, ly), world_coord(m.px, rxx, rxy, lx, ly)};
  endfunction

  class position_scoreboard;
    logic [OutDataW-1:0] pending[$];
    int errors = 0;

    function void note_input(motion_t m, logic [ThrW-1:0] thr);
      pending.push_back(predict_position(m, thr));
    endfunction

    function void check_word(logic [OutDataW-1:0] got);
      logic [OutDataW-1:0] exp_word;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %h", got);
        return;
      end
      exp_word = pending.pop_front();
      if (got[PosW-1:0] !== exp_word[PosW-1:0] ||
          got[2*PosW-1:PosW] !== exp_word[2*PosW-1:PosW]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: x exp %h got %h, y exp %h got %h",
                   exp_word[PosW-1:0], got[PosW-1:0],
                   exp_word[2*PosW-1:PosW], got[2*PosW-1:PosW]);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_wr_en_i = 0;
  logic [ThrW-1:0] cfg_wr_data_i = '0;

  position_scoreboard board = new();
  logic [ThrW-1:0] cur_thr = ThrReset;
  motion_t cur_item;
  bit hold_long = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  ctrv_future_position dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_wr_en_i, .cfg_wr_data_i
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // accepted words: notes inputs, checks outputs, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_input(cur_item, cur_thr);
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (stim_done && board.pending.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= Limit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk_i);
        hold_long = 0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g - 1) @(negedge clk_i);
      end else
        m_axis_tready <= 1;
    end
  end

  // tvalid stays high after the accept; the next gap or the caller drops it
  task automatic send_item(motion_t m);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    cur_item = m;
    s_axis_tdata <= {m.qz, m.qy, m.qx, m.qw, m.heading, m.py, m.px,
                     m.horizon, m.yaw, m.speed};
    s_axis_tuser <= m.use_quat;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] thr);
    s_axis_tvalid <= 0;
    wait (board.pending.size() == 0);
    @(negedge clk_i);
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= thr;
    @(negedge clk_i);
    cfg_wr_en_i <= 0;
    cur_thr = thr;
  endtask

  function automatic logic signed [QuatW-1:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 18'sh10000;
      1: return -18'sh10000;
      2: return 18'($urandom());
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic motion_t rand_motion();
    motion_t m;
    m.speed   = 24'($urandom());
    m.yaw     = 21'($urandom());
    if ($urandom_range(0, 3) == 0) m.yaw = 21'($signed($urandom_range(0, 40)) - 20);
    m.horizon = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 655360));
    m.px      = 48'({$urandom(), $urandom()});
    m.py      = 48'({$urandom(), $urandom()});
    if ($urandom_range(0, 1)) begin
      m.px = 48'($signed($urandom_range(0, 200000000)) - 100000000);
      m.py = 48'($signed($urandom_range(0, 200000000)) - 100000000);
    end
    m.heading = ($urandom_range(0, 4) == 0) ? 19'($urandom())
                : 19'($signed($urandom_range(0, 411775)) - 205888);
    m.use_quat = 1'($urandom_range(0, 1));
    m.qw = rand_quat();
    m.qx = rand_quat();
    m.qy = rand_quat();
    m.qz = rand_quat();
    return m;
  endfunction

  initial begin
    motion_t m;
    logic [ThrW-1:0] thr_set[4];
    thr_set = '{20'd0, ThrMax, 20'd7, 20'd3000};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: extremes, straight and arc, both rotations, zero yaw at zero threshold
    m = rand_motion();
    m.speed = 24'sh7FFFFF; m.yaw = 21'sh0FFFFF; m.horizon = 24'hFFFFFF;
    m.px = 48'sh7FFFFFFFFFFF; m.py = 48'sh800000000000; m.use_quat = 0;
    m.heading = 19'sh3FFFF;
    send_item(m);
    m.speed = 24'sh800000; m.yaw = 21'sh100000; m.heading = 19'sh40000;
    m.px = 48'sh800000000000; m.py = 48'sh7FFFFFFFFFFF;
    send_item(m);
    m.use_quat = 1; m.qw = 18'sh10000; m.qx = '0; m.qy = '0; m.qz = '0; m.yaw = '0;
    send_item(m);
    m.qw = -18'sh10000; m.qx = -18'sh10000; m.qy = 18'sh10000; m.qz = -18'sh10000;
    m.yaw = 21'sd6; m.speed = 24'sd65536; m.horizon = 24'd65536;
    send_item(m);
    m.yaw = 21'sd7; m.qx = 18'sh1FFFF; m.qy = 18'sh20000;
    send_item(m);
    m.yaw = -21'sd7; m.horizon = '0; m.px = '0; m.py = '0;
    send_item(m);
    m.use_quat = 0; m.heading = -19'sd205888; m.yaw = 21'sd102944; m.horizon = 24'd131072;
    send_item(m);
    m.heading = 19'sd205887;
    send_item(m);
    for (int k = 0; k < 4; k++) begin
      write_threshold(thr_set[k]);
      m = rand_motion();
      m.yaw = '0;
      send_item(m);
      m.yaw = 21'(thr_set[k]);
      send_item(m);
      m.yaw = -21'sd1;
      send_item(m);
    end

    // random phases, one threshold each; long receiver hold-off in the first
    for (int p = 0; p < 4; p++) begin
      write_threshold(p == 3 ? ThrMax : 20'($urandom_range(0, 70000)));
      if (p == 0) hold_long = 1;
      for (int i = 0; i < NumRandom / 4; i++) begin
        if (p == 0 && i < 150) begin
          // back-to-back so the pipeline fills behind the stalled output
          m = rand_motion();
          cur_item = m;
          s_axis_tdata <= {m.qz, m.qy, m.qx, m.qw, m.heading, m.py, m.px,
                           m.horizon, m.yaw, m.speed};
          s_axis_tuser <= m.use_quat;
          s_axis_tvalid <= 1;
          do @(posedge clk_i); while (!s_axis_tready);
          @(negedge clk_i);
        end else
          send_item(rand_motion());
      end
    end
    s_axis_tvalid <= 0;

    stim_done = 1;
    wait (board.pending.size() == 0);
    repeat (DrainWait) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ctrv_pkg.sv
hdl/ctrv_trig.sv
hdl/ctrv_div.sv
hdl/ctrv_future_position.sv
sim/testbench.sv
